// ===== hdl/dbsm_pkg.sv =====
// Package with the types and constants of the draw batch sphere merger.
package dbsm_pkg;

   localparam int FIELD_LIMIT = 65536;
   localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;
   localparam int ROOT_BITS = 34;
   localparam logic [5:0] ITER_TOP = 6'(ROOT_BITS - 1);
   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [63:0]        batch_key;
      logic               casts_shadow;
      logic               is_transparent;
      logic signed [31:0] sphere_x;
      logic signed [31:0] sphere_y;
      logic signed [31:0] sphere_z;
      logic signed [31:0] sphere_radius;
   } req_type;

   typedef struct packed {
      logic [15:0]        first_instance;
      logic [16:0]        instance_count;
      logic signed [31:0] bound_x;
      logic signed [31:0] bound_y;
      logic signed [31:0] bound_z;
      logic [30:0]        bound_radius;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SUMSQ,
      ST_SQRT,
      ST_CHOOSE,
      ST_PRODUCT,
      ST_DIVIDE,
      ST_MOVE
   } state_type;

   typedef struct packed {
      logic capture;
      logic emit;
      logic flush_clear;
      logic open_batch;
      logic count_inc;
      logic set_draw;
      logic sumsq_step;
      logic sqrt_step;
      logic keep_max;
      logic nk_load;
      logic prod_step;
      logic div_step;
      logic move_step;
   } cmd_type;

   typedef struct packed {
      logic need_emit;
      logic rsp_busy;
      logic is_flush;
      logic keep;
      logic same;
      logic r_zero;
      logic big_r_zero;
      logic ax_last;
      logic iter_done;
      logic contained;
      logic swallow;
      logic d_zero;
   } status_type;

endpackage

// ===== hdl/dbsm_ctrl.sv =====
// Controller state machine of the draw batch sphere merger.
module dbsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dbsm_pkg::status_type status,
   output dbsm_pkg::cmd_type    cmd
);
   import dbsm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!(status.need_emit && status.rsp_busy)) begin
               if (status.is_flush || !status.keep || !status.same || status.r_zero
                   || status.big_r_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SUMSQ;
               end
            end
         end
         ST_SUMSQ: begin
            if (status.ax_last) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.iter_done) state_in = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            if (status.contained || status.swallow || status.d_zero) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PRODUCT;
            end
         end
         ST_PRODUCT: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.iter_done) state_in = ST_MOVE;
         end
         ST_MOVE: begin
            state_in = status.ax_last ? ST_IDLE : ST_PRODUCT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.capture = req_valid;
         ST_DECIDE: begin
            if (!(status.need_emit && status.rsp_busy)) begin
               cmd.emit = status.need_emit;
               if (status.is_flush) begin
                  cmd.flush_clear = 1'b1;
               end else if (status.keep && !status.same) begin
                  cmd.open_batch = 1'b1;
               end else if (status.keep) begin
                  cmd.count_inc = 1'b1;
                  cmd.set_draw  = status.big_r_zero && !status.r_zero;
               end
            end
         end
         ST_SUMSQ: cmd.sumsq_step = 1'b1;
         ST_SQRT: cmd.sqrt_step = 1'b1;
         ST_CHOOSE: begin
            if (status.contained) begin
               cmd = '0;
            end else if (status.swallow) begin
               cmd.set_draw = 1'b1;
            end else if (status.d_zero) begin
               cmd.keep_max = 1'b1;
            end else begin
               cmd.nk_load = 1'b1;
            end
         end
         ST_PRODUCT: cmd.prod_step = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_MOVE: cmd.move_step = 1'b1;
         default: cmd = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== hdl/dbsm_datapath.sv =====
// Datapath of the draw batch sphere merger: batch state, root, divider, output register.
module dbsm_datapath #(
   parameter int MAX_INSTANCES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dbsm_pkg::req_type    req_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output dbsm_pkg::rsp_type    rsp_data,
   input  dbsm_pkg::cmd_type    cmd,
   output dbsm_pkg::status_type status
);
   import dbsm_pkg::*;

   localparam int LIMIT = (MAX_INSTANCES < FIELD_LIMIT) ? MAX_INSTANCES : FIELD_LIMIT;

   req_type            req_ff;
   logic               open_ff;
   logic [63:0]        key_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff;
   logic [15:0]        first_ff;
   logic [16:0]        count_ff;
   logic [16:0]        next_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic [1:0]         ax_ff;
   logic [5:0]         iter_ff;
   logic [67:0]        sumsq_ff;
   logic [33:0]        root_ff;
   logic [34:0]        n_ff;
   logic [33:0]        k_ff;
   logic [67:0]        num_ff;
   logic [33:0]        rem_ff;
   logic [33:0]        q_ff;

   logic [30:0]        r_draw;
   logic signed [31:0] draw_sel, cen_sel;
   logic signed [32:0] delta;
   logic [32:0]        mag;
   logic [65:0]        sq;
   logic [33:0]        cand;
   logic [67:0]        cand_sq;
   logic [35:0]        d_plus_r, d_plus_big, n_sum;
   logic [34:0]        k_full;
   logic [67:0]        prod;
   logic [34:0]        trial;
   logic               trial_ok;
   logic [33:0]        q_clamp;
   logic signed [34:0] moved;
   logic signed [31:0] moved_sat;

   assign r_draw = req_ff.sphere_radius[31] ? 31'd0 : req_ff.sphere_radius[30:0];

   always_comb begin
      case (ax_ff)
         2'd0:    begin draw_sel = req_ff.sphere_x; cen_sel = cx_ff; end
         2'd1:    begin draw_sel = req_ff.sphere_y; cen_sel = cy_ff; end
         default: begin draw_sel = req_ff.sphere_z; cen_sel = cz_ff; end
      endcase
   end

   assign delta   = 33'(draw_sel) - 33'(cen_sel);
   assign mag     = delta[32] ? 33'(-delta) : 33'(delta);
   assign sq      = 66'(mag) * 66'(mag);
   assign cand    = root_ff | (34'd1 << iter_ff);
   assign cand_sq = 68'(cand) * 68'(cand);

   assign d_plus_r   = 36'(root_ff) + 36'(r_draw);
   assign d_plus_big = 36'(root_ff) + 36'(rad_ff);
   assign n_sum      = 36'(root_ff) + 36'(rad_ff) + 36'(r_draw);
   assign k_full     = n_sum[35:1] - 35'(rad_ff);

   assign prod     = 68'(mag) * 68'(k_ff) + 68'(root_ff[33:1]);
   assign trial    = {rem_ff, num_ff[iter_ff]};
   assign trial_ok = (trial >= {1'b0, root_ff});

   assign q_clamp = (q_ff > {1'b0, mag}) ? {1'b0, mag} : q_ff;
   assign moved   = delta[32] ? (35'(cen_sel) - $signed({1'b0, q_clamp}))
                              : (35'(cen_sel) + $signed({1'b0, q_clamp}));
   always_comb begin
      if (moved > 35'sd2147483647) begin
         moved_sat = 32'sh7FFF_FFFF;
      end else if (moved < -35'sd2147483648) begin
         moved_sat = 32'sh8000_0000;
      end else begin
         moved_sat = moved[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         key_ff       <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         rad_ff       <= '0;
         first_ff     <= '0;
         count_ff     <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= '0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.flush_clear) begin
            open_ff  <= 1'b0;
            count_ff <= '0;
            next_ff  <= '0;
         end
         if (cmd.open_batch) begin
            open_ff  <= 1'b1;
            key_ff   <= req_ff.batch_key;
            first_ff <= next_ff[15:0];
            count_ff <= 17'd1;
            next_ff  <= next_ff + 17'd1;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + 17'd1;
            next_ff  <= next_ff + 17'd1;
         end
         if (cmd.set_draw || cmd.open_batch) begin
            cx_ff  <= req_ff.sphere_x;
            cy_ff  <= req_ff.sphere_y;
            cz_ff  <= req_ff.sphere_z;
            rad_ff <= r_draw;
         end
         if (cmd.keep_max && (r_draw > rad_ff)) begin
            rad_ff <= r_draw;
         end
         if (cmd.sumsq_step || cmd.move_step) begin
            ax_ff <= (ax_ff == AXIS_LAST) ? 2'd0 : ax_ff + 2'd1;
         end
         if (cmd.move_step) begin
            case (ax_ff)
               2'd0:    cx_ff <= moved_sat;
               2'd1:    cy_ff <= moved_sat;
               default: cz_ff <= moved_sat;
            endcase
            if (ax_ff == AXIS_LAST) begin
               rad_ff <= (n_ff > 35'(RADIUS_MAX)) ? RADIUS_MAX : n_ff[30:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.emit) begin
         rsp_ff.first_instance <= first_ff;
         rsp_ff.instance_count <= count_ff;
         rsp_ff.bound_x        <= cx_ff;
         rsp_ff.bound_y        <= cy_ff;
         rsp_ff.bound_z        <= cz_ff;
         rsp_ff.bound_radius   <= rad_ff;
      end
      if (cmd.sumsq_step) begin
         sumsq_ff <= (ax_ff == 2'd0) ? 68'(sq) : sumsq_ff + 68'(sq);
         if (ax_ff == AXIS_LAST) begin
            iter_ff <= ITER_TOP;
            root_ff <= '0;
         end
      end
      if (cmd.sqrt_step) begin
         if (cand_sq <= sumsq_ff) root_ff <= cand;
         iter_ff <= iter_ff - 6'd1;
      end
      if (cmd.nk_load) begin
         n_ff <= n_sum[35:1];
         k_ff <= k_full[33:0];
      end
      if (cmd.prod_step) begin
         num_ff  <= prod;
         rem_ff  <= prod[67:34];
         q_ff    <= '0;
         iter_ff <= ITER_TOP;
      end
      if (cmd.div_step) begin
         rem_ff  <= trial_ok ? 34'(trial - {1'b0, root_ff}) : trial[33:0];
         q_ff    <= {q_ff[32:0], trial_ok};
         iter_ff <= iter_ff - 6'd1;
      end
   end

   always_comb begin
      status.is_flush   = req_ff.kind;
      status.keep       = req_ff.casts_shadow && !req_ff.is_transparent
                          && (next_ff < 17'(LIMIT));
      status.same       = open_ff && (req_ff.batch_key == key_ff);
      status.need_emit  = open_ff && (req_ff.kind || (status.keep && !status.same));
      status.rsp_busy   = rsp_valid_ff && rsp_stall;
      status.r_zero     = (r_draw == 31'd0);
      status.big_r_zero = (rad_ff == 31'd0);
      status.ax_last    = (ax_ff == AXIS_LAST);
      status.iter_done  = (iter_ff == 6'd0);
      status.contained  = (36'(rad_ff) >= d_plus_r);
      status.swallow    = (36'(r_draw) >= d_plus_big);
      status.d_zero     = (root_ff == 34'd0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/draw_batch_sphere_merger_core.sv =====
// Top level of the draw batch sphere merger: controller, datapath and checks.
//
// This block groups an ordered stream of draw requests into batches of equal
// key, dropping requests that cast no shadow, are transparent or come once
// the instance limit is reached, and keeps for each batch its first instance
// index, its count and a bounding sphere that covers every member. A batch is
// emitted when a kept request brings a new key or when a flush request arrives;
// a flush also restarts instance numbering. One request is processed at
// a time. A dropped request, a flush or a request that opens a batch ends at
// the decide state, as does a merge in which either radius is zero. A full
// merge of a sphere into an open batch passes through the idle and decide
// states, a sum of the squared centre distances over the three axes, a
// bit-per-cycle square root, a classification of the overlap, then for each
// of the three axes a multiply, a restoring divider and a move of the centre.
// A merge that ends at the overlap check (containment either way or coincident
// centres) skips the per-axis steps. A result waiting at the output does not
// block the next request; it holds back only a request that must itself emit
// a batch, which then waits in the decide state until the result is taken.
module draw_batch_sphere_merger_core #(
   parameter int MAX_INSTANCES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dbsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dbsm_pkg::rsp_type rsp_data
);
   import dbsm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences the merge and holds the state register; the datapath owns every other register.
   dbsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dbsm_datapath #(
      .MAX_INSTANCES (MAX_INSTANCES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   // A request just taken keeps the input stalled while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after a request was accepted");

   // An emitted batch always holds at least one instance.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.instance_count != 17'd0))
      else $error("emitted batch with no instances");

   // A batch never reaches beyond the instance index range.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((18'(rsp_data.first_instance) + 18'(rsp_data.instance_count))
                     <= 18'(FIELD_LIMIT)))
      else $error("emitted batch exceeds the instance range");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the draw batch sphere merger core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dbsm_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int TAIL_CYCLES = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   draw_batch_sphere_merger_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Predictor state, mirroring the block's own registers.
   logic               pr_open;
   logic [63:0]        pr_key;
   logic signed [63:0] pr_cx, pr_cy, pr_cz;
   logic [63:0]        pr_rad;
   logic [15:0]        pr_first;
   logic [16:0]        pr_count;
   logic [63:0]        pr_next;

   req_type pending_requests[$];
   rsp_type expected_batches[$];
   int      fail_count = 0;
   bit      stimulus_done = 1'b0;
   bit      hold_off = 1'b0;

   task automatic queue_request(req_type q);
      pending_requests.insert(pending_requests.size(), q);
   endtask

   function automatic logic [63:0] isqrt68(logic [67:0] v);
      logic [67:0] res;
      logic [67:0] c;
      res = '0;
      for (int b = 33; b >= 0; b--) begin
         c = res | (68'd1 << b);
         if (c * c <= v) res = c;
      end
      return res[63:0];
   endfunction

   function automatic logic signed [63:0] shift_axis(logic signed [63:0] c,
         logic signed [63:0] target, logic [63:0] k, logic [63:0] d);
      logic signed [63:0] delta;
      logic [127:0] mag;
      logic [127:0] q;
      logic signed [63:0] r;
      delta = target - c;
      mag = (delta < 0) ? 128'(-delta) : 128'(delta);
      q = (mag * 128'(k) + 128'(d >> 1)) / 128'(d);
      if (q > mag) q = mag;
      r = (delta < 0) ? c - 64'(q) : c + 64'(q);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   task automatic take_sphere(logic signed [63:0] x, y, z, logic [63:0] r);
      pr_cx = x; pr_cy = y; pr_cz = z; pr_rad = r;
   endtask

   task automatic merge_sphere(logic signed [63:0] x, y, z, logic [63:0] r);
      logic signed [63:0] dx, dy, dz;
      logic [67:0] sum;
      logic [63:0] d, n, k;
      if (r == 0) return;
      if (pr_rad == 0) begin
         take_sphere(x, y, z, r);
         return;
      end
      dx = x - pr_cx; dy = y - pr_cy; dz = z - pr_cz;
      // Squares are formed at full width: a 33-bit difference squared overflows 64 bits.
      sum = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
      d = isqrt68(sum);
      if (pr_rad >= d + r) return;
      if (r >= d + pr_rad) begin
         take_sphere(x, y, z, r);
         return;
      end
      if (d == 0) begin
         if (r > pr_rad) pr_rad = r;
         return;
      end
      n = (d + pr_rad + r) >> 1;
      k = n - pr_rad;
      pr_cx = shift_axis(pr_cx, x, k, d);
      pr_cy = shift_axis(pr_cy, y, k, d);
      pr_cz = shift_axis(pr_cz, z, k, d);
      pr_rad = (n > 64'(RADIUS_MAX)) ? 64'(RADIUS_MAX) : n;
   endtask

   task automatic close_batch();
      rsp_type b;
      b.first_instance = pr_first;
      b.instance_count = pr_count;
      b.bound_x = pr_cx[31:0];
      b.bound_y = pr_cy[31:0];
      b.bound_z = pr_cz[31:0];
      b.bound_radius = pr_rad[30:0];
      expected_batches.insert(expected_batches.size(), b);
   endtask

   // Works out what one accepted request does to the batch state.
   task automatic predict_batch(req_type q);
      logic [63:0] r;
      if (q.kind) begin
         if (pr_open) close_batch();
         pr_open = 1'b0;
         pr_count = '0;
         pr_next = '0;
         return;
      end
      if (!q.casts_shadow || q.is_transparent) return;
      if (pr_next >= 64'(FIELD_LIMIT)) return;
      r = (q.sphere_radius < 0) ? 64'd0 : 64'(q.sphere_radius);
      if (pr_open && q.batch_key == pr_key) begin
         pr_count++;
         merge_sphere(64'(q.sphere_x), 64'(q.sphere_y), 64'(q.sphere_z), r);
      end else begin
         if (pr_open) close_batch();
         pr_open = 1'b1;
         pr_key = q.batch_key;
         pr_first = pr_next[15:0];
         pr_count = 17'd1;
         take_sphere(64'(q.sphere_x), 64'(q.sphere_y), 64'(q.sphere_z), r);
      end
      pr_next++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   function automatic req_type make_draw(logic [63:0] key, logic [31:0] x, y, z, rad);
      req_type q;
      q = '0;
      q.batch_key = key;
      q.casts_shadow = 1'b1;
      q.sphere_x = x; q.sphere_y = y; q.sphere_z = z;
      q.sphere_radius = rad;
      return q;
   endfunction

   function automatic req_type make_random(logic [63:0] key);
      req_type q;
      q = make_draw(key, rand_coord(), rand_coord(), rand_coord(), 32'd0);
      case ($urandom_range(0, 7))
         0: q.sphere_radius = $urandom();
         1: q.sphere_radius = 32'h7FFF_FFFF;
         2: q.sphere_radius = -$signed($urandom_range(1, 1000));
         3: q.sphere_radius = 32'd0;
         default: q.sphere_radius = $urandom_range(1, 32'h0030_0000);
      endcase
      if ($urandom_range(0, 15) == 0) q.casts_shadow = 1'b0;
      if ($urandom_range(0, 15) == 0) q.is_transparent = 1'b1;
      return q;
   endfunction

   // Fills the queue: directed cases first, then random runs of equal keys with occasional flushes.
   initial begin
      req_type q;
      logic [63:0] key;
      int run_len;
      queue_request(make_draw(64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h0, 32'h0001_0000));
      queue_request(make_draw(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      // Containment both ways, coincident centres and a negative radius.
      queue_request(make_draw(64'd1, 32'd0, 32'd0, 32'd0, 32'h0010_0000));
      queue_request(make_draw(64'd1, 32'h100, 32'd0, 32'd0, 32'h1000));
      queue_request(make_draw(64'd1, 32'h100, 32'd0, 32'd0, 32'h0100_0000));
      queue_request(make_draw(64'd1, 32'h100, 32'd0, 32'd0, 32'h0200_0000));
      queue_request(make_draw(64'd1, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000));
      queue_request(make_draw(64'd1, 32'h0300_0000, 32'hFD00_0000,
         32'h0100_0000, 32'h0080_0000));
      queue_request(make_draw(64'd2, 32'd5, 32'd5, 32'd5, 32'h8000_0000));
      queue_request(make_draw(64'd2, 32'd5, 32'd5, 32'd5, 32'h0000_0010));
      q = make_draw(64'd2, 32'd9, 32'd9, 32'd9, 32'd9);
      q.casts_shadow = 1'b0;
      queue_request(q);
      q.casts_shadow = 1'b1; q.is_transparent = 1'b1;
      queue_request(q);
      q = '1;
      queue_request(q);
      q = '0; q.kind = 1'b1;
      queue_request(q);
      queue_request(make_draw(64'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      queue_request(make_draw(64'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF));
      queue_request(make_draw(64'd0, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h7FFF_FFFF));
      while (pending_requests.size() < 1600) begin
         key = {$urandom(), $urandom()};
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 6);
         for (int i = 0; i < run_len; i++) queue_request(make_random(key));
         if ($urandom_range(0, 9) == 0) begin
            q = {3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom()};
            q.kind = 1'b1;
            queue_request(q);
         end
      end
      q = '0; q.kind = 1'b1;
      queue_request(q);
   end

   // Driver: bursts of requests separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // Hold the offered request unchanged.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
         req_valid <= 1'b0;
         stimulus_done <= 1'b1;
      end else begin
         req_data <= pending_requests.pop_front();
         req_valid <= 1'b1;
         if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) predict_batch(req_data);
   end

   // Receiver stall pattern, with one long hold-off early in the run.
   int stall_cycles = 0;
   int accepted_reqs = 0;
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) accepted_reqs <= accepted_reqs + 1;
      if (!hold_off && accepted_reqs == 30) begin
         hold_off <= 1'b1;
         stall_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
      end else begin
         rsp_stall <= (accepted_reqs[8]) ? ($urandom_range(0, 3) == 0) : 1'b0;
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_batches.size() == 0) begin
            $error("unexpected batch result %p", rsp_data);
            fail_count++;
         end else begin
            e = expected_batches.pop_front();
            if (rsp_data.first_instance !== e.first_instance) begin
               $error("first_instance expected %0d got %0d", e.first_instance,
                  rsp_data.first_instance);
               fail_count++;
            end
            if (rsp_data.instance_count !== e.instance_count) begin
               $error("instance_count expected %0d got %0d", e.instance_count,
                  rsp_data.instance_count);
               fail_count++;
            end
            if (rsp_data.bound_x !== e.bound_x) begin
               $error("bound_x expected %0d got %0d", e.bound_x, rsp_data.bound_x);
               fail_count++;
            end
            if (rsp_data.bound_y !== e.bound_y) begin
               $error("bound_y expected %0d got %0d", e.bound_y, rsp_data.bound_y);
               fail_count++;
            end
            if (rsp_data.bound_z !== e.bound_z) begin
               $error("bound_z expected %0d got %0d", e.bound_z, rsp_data.bound_z);
               fail_count++;
            end
            if (rsp_data.bound_radius !== e.bound_radius) begin
               $error("bound_radius expected %0d got %0d", e.bound_radius,
                  rsp_data.bound_radius);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      pr_open = 1'b0; pr_key = '0; pr_cx = '0; pr_cy = '0; pr_cz = '0;
      pr_rad = '0; pr_first = '0; pr_count = '0; pr_next = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_batches.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_batches.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
